// File: rtl/message_ring_with_jam_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the message ring with jam
// Shared property shapes: same-cycle and next-cycle implication on clk,
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef MESSAGE_RING_WITH_JAM_CORE_ASSERT_SVH
`define MESSAGE_RING_WITH_JAM_CORE_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define MRJ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define MRJ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mrj_pkg.sv
// ----------------------------------------------------------------------------
// mrj_pkg
// Types and fixed constants shared by the message ring with jam.
// ----------------------------------------------------------------------------
package mrj_pkg;

	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int CAP_W      = 7;
	localparam int COUNT_W    = 7;
	localparam int MSG_PORT_W = 32;

	localparam logic [CAP_W-1:0] CAP_RESET = 7'd64;

	typedef enum logic [OP_W-1:0] {
		OP_POST    = 2'd0,
		OP_JAM     = 2'd1,
		OP_ACCEPT  = 2'd2,
		OP_INQUIRY = 2'd3
	} op_t;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	// Decoded operation, one-hot, raised in the cycle an item transfers in.
	typedef struct packed {
		logic post;
		logic jam;
		logic take;
		logic peek;
	} cmd_t;

endpackage

// File: rtl/message_ring_with_jam_core.sv
// Timing: a result is offered in the cycle after its item transfers in.
// Flow: the controller holds one item at a time and reopens the input after
//   the transfer out.
// Reset: arst_n clears indices, fill count and handshake state and loads capacity 64;
//   slot contents are left as they are and are only read after being written.
// ----------------------------------------------------------------------------
// message_ring_with_jam_core
// Single message queue held in a ring of capacity+1 slots. Post appends at
// the tail and is refused when full; jam inserts ahead of the head and may
// use the spare slot; accept removes the head; inquiry peeks at the head.
// ----------------------------------------------------------------------------
module message_ring_with_jam_core #(
	parameter int MAX_DEPTH = 64,
	parameter int MSG_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// Capacity register write; empties the queue.
	input  logic                            cfg_we,
	input  logic [mrj_pkg::CAP_W-1:0]       cfg_wdata,
	// Operation channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [mrj_pkg::OP_W-1:0]        op,
	input  logic [mrj_pkg::MSG_PORT_W-1:0]  message,
	// Result channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [mrj_pkg::STATUS_W-1:0]    status,
	output logic [mrj_pkg::MSG_PORT_W-1:0]  message_out,
	output logic [mrj_pkg::COUNT_W-1:0]     count
);

	mrj_pkg::cmd_t cmd;

	// Controller: decode op on an input transfer, hold the result until
	// the output transfer completes.
	mrj_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.op        (op),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	// Datapath: ring memory, head/tail indices, fill count and the
	// registered result fields. The head slot is read into a register
	// in the transfer cycle, so the message is ready when out_valid rises.
	mrj_datapath #(
		.MAX_DEPTH (MAX_DEPTH),
		.MSG_WIDTH (MSG_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.cmd         (cmd),
		.message     (message),
		.status      (status),
		.message_out (message_out),
		.count       (count)
	);

endmodule

// File: rtl/mrj_ctrl.sv
// ----------------------------------------------------------------------------
// mrj_ctrl
// Handshake controller: takes one item, holds its result until transferred.
// ----------------------------------------------------------------------------
module mrj_ctrl (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [mrj_pkg::OP_W-1:0]     op,
	output logic                         out_valid,
	input  logic                         out_stall,
	output mrj_pkg::cmd_t                cmd
);

	typedef enum logic {
		S_IDLE,
		S_HOLD
	} state_t;

	state_t state_q;
	logic   in_stall_q;
	logic   out_valid_q;
	logic   take_in;

	assign take_in   = in_valid && !in_stall_q;
	assign in_stall  = in_stall_q;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd = '0;
		if (take_in) begin
			case (op)
				mrj_pkg::OP_POST:    cmd.post = 1'b1;
				mrj_pkg::OP_JAM:     cmd.jam  = 1'b1;
				mrj_pkg::OP_ACCEPT:  cmd.take = 1'b1;
				mrj_pkg::OP_INQUIRY: cmd.peek = 1'b1;
				default:             cmd      = '0;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_stall_q  <= 1'b1;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (take_in) begin
						state_q     <= S_HOLD;
						in_stall_q  <= 1'b1;
						out_valid_q <= 1'b1;
					end else begin
						in_stall_q  <= 1'b0;
					end
				end
				S_HOLD: begin
					if (!out_stall) begin
						state_q     <= S_IDLE;
						in_stall_q  <= 1'b0;
						out_valid_q <= 1'b0;
					end
				end
				default: begin
					state_q     <= S_IDLE;
					in_stall_q  <= 1'b1;
					out_valid_q <= 1'b0;
				end
			endcase
		end
	end

endmodule

// File: rtl/mrj_datapath.sv
// ----------------------------------------------------------------------------
// mrj_datapath
// Ring storage, read/write indices, fill count and result registers.
// ----------------------------------------------------------------------------
module mrj_datapath #(
	parameter int MAX_DEPTH = 64,
	parameter int MSG_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [mrj_pkg::CAP_W-1:0]       cfg_wdata,
	input  mrj_pkg::cmd_t                   cmd,
	input  logic [mrj_pkg::MSG_PORT_W-1:0]  message,
	output logic [mrj_pkg::STATUS_W-1:0]    status,
	output logic [mrj_pkg::MSG_PORT_W-1:0]  message_out,
	output logic [mrj_pkg::COUNT_W-1:0]     count
);

	localparam int CAP_MAX = (1 << mrj_pkg::CAP_W) - 1;
	localparam int EFF_MAX = (MAX_DEPTH > CAP_MAX) ? CAP_MAX : MAX_DEPTH;
	localparam int SLOTS   = EFF_MAX + 1;
	localparam int IDX_W   = $clog2(SLOTS);
	localparam int USED_W  = $clog2(SLOTS + 1);
	localparam int PW      = mrj_pkg::MSG_PORT_W;
	localparam int CW      = mrj_pkg::COUNT_W;

	logic [MSG_WIDTH-1:0]          mem_q [SLOTS];
	logic [MSG_WIDTH-1:0]          rd_data_q;
	logic [mrj_pkg::CAP_W-1:0]     capacity_q;
	logic [IDX_W-1:0]              ri_q;
	logic [IDX_W-1:0]              wi_q;
	logic [USED_W-1:0]             used_q;
	logic [mrj_pkg::STATUS_W-1:0]  status_q;
	logic [USED_W-1:0]             count_q;
	logic                          rd_sel_q;

	logic [IDX_W-1:0]              cap_eff;
	logic [USED_W-1:0]             cap_used;
	logic                          full_post;
	logic                          full_jam;
	logic                          empty;
	logic [IDX_W-1:0]              ri_inc;
	logic [IDX_W-1:0]              ri_dec;
	logic [IDX_W-1:0]              wi_inc;
	logic                          do_post;
	logic                          do_jam;
	logic                          do_take;
	logic                          do_read;
	logic                          mem_we;
	logic [IDX_W-1:0]              mem_waddr;
	logic [mrj_pkg::STATUS_W-1:0]  status_nx;
	logic [USED_W-1:0]             used_nx;

	// Capacity saturates at MAX_DEPTH (at most 127), one below the slot count.
	assign cap_eff   = (int'(capacity_q) > EFF_MAX) ? IDX_W'(EFF_MAX) : capacity_q[IDX_W-1:0];
	assign cap_used  = USED_W'(cap_eff);
	assign full_post = used_q >= cap_used;
	assign full_jam  = used_q > cap_used;
	assign empty     = (used_q == '0);

	assign ri_inc = (ri_q >= cap_eff) ? '0 : ri_q + 1'b1;
	assign ri_dec = (ri_q == '0) ? cap_eff : ri_q - 1'b1;
	assign wi_inc = (wi_q >= cap_eff) ? '0 : wi_q + 1'b1;

	assign do_post   = cmd.post && !full_post;
	assign do_jam    = cmd.jam && !full_jam;
	assign do_take   = cmd.take && !empty;
	assign do_read   = (cmd.take || cmd.peek) && !empty;
	assign mem_we    = do_post || do_jam;
	assign mem_waddr = do_jam ? ri_dec : wi_q;

	// Fill count after the operation.
	assign used_nx = (do_post || do_jam) ? used_q + 1'b1 :
	                 do_take             ? used_q - 1'b1 : used_q;

	always_comb begin
		status_nx = mrj_pkg::ST_OK;
		if ((cmd.post && full_post) || (cmd.jam && full_jam)) begin
			status_nx = mrj_pkg::ST_FULL;
		end else if (cmd.take && empty) begin
			status_nx = mrj_pkg::ST_EMPTY;
		end
	end

	// Slot storage: one write port, one registered read port at the head.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= MSG_WIDTH'(message);
		end
		if (do_read) begin
			rd_data_q <= mem_q[ri_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= mrj_pkg::CAP_RESET;
			ri_q       <= '0;
			wi_q       <= '0;
			used_q     <= '0;
			status_q   <= mrj_pkg::ST_OK;
			count_q    <= '0;
			rd_sel_q   <= 1'b0;
		end else if (cfg_we) begin
			// Empty the queue on a capacity write.
			capacity_q <= cfg_wdata;
			ri_q       <= '0;
			wi_q       <= '0;
			used_q     <= '0;
		end else if (cmd.post || cmd.jam || cmd.take || cmd.peek) begin
			rd_sel_q <= do_read;
			status_q <= status_nx;
			count_q  <= used_nx;
			used_q   <= used_nx;
			if (do_post) begin
				wi_q <= wi_inc;
			end
			if (do_jam) begin
				ri_q <= ri_dec;
			end else if (do_take) begin
				ri_q <= ri_inc;
			end
		end
	end

	assign status      = status_q;
	assign message_out = rd_sel_q ? PW'(rd_data_q) : '0;
	assign count       = CW'(count_q);

endmodule

// File: rtl/mrj_checker.sv
// ----------------------------------------------------------------------------
// mrj_checker
// Port-level checks on the message ring with jam, bound to the top level.
// ----------------------------------------------------------------------------
`include "message_ring_with_jam_core_assert.svh"

module mrj_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            in_valid,
	input logic                            in_stall,
	input logic                            out_valid,
	input logic                            out_stall,
	input logic [mrj_pkg::STATUS_W-1:0]    status,
	input logic [mrj_pkg::MSG_PORT_W-1:0]  message_out,
	input logic [mrj_pkg::COUNT_W-1:0]     count
);

	// One item at a time: a transfer in closes the input and offers a result.
	`MRJ_ASSERT_NEXT(a_one_in_flight, in_valid && !in_stall, in_stall && out_valid, "input open while a result is pending")

	// A refused post or jam carries no message.
	`MRJ_ASSERT_NOW(a_full_no_msg, out_valid && status == mrj_pkg::ST_FULL, message_out == '0, "full result carries a message")

	// An empty accept reports an empty queue and no message.
	`MRJ_ASSERT_NOW(a_empty_zero, out_valid && status == mrj_pkg::ST_EMPTY, count == '0 && message_out == '0, "empty result with nonzero count or message")

	// A stalled result stays offered with the same count.
	`MRJ_ASSERT_NEXT(a_hold_result, out_valid && out_stall, out_valid && $stable(count), "stalled result dropped or changed")

endmodule

bind message_ring_with_jam_core mrj_checker u_mrj_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.status      (status),
	.message_out (message_out),
	.count       (count)
);

// File: tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for message_ring_with_jam_core. Directed tests cover
// the empty, full and zero-capacity corners, jam into the spare slot and a
// saturated capacity. Random traffic then fills and drains rings of many
// sizes under three handshake idling profiles. A ring predictor in the
// bench computes each result, and a monitor checks every output transfer.
// ----------------------------------------------------------------------------
module testbench;

	localparam int RING_DEPTH  = 64;
	localparam int CYCLE_LIMIT = 500000;
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		logic [mrj_pkg::STATUS_W-1:0]   status;
		logic [mrj_pkg::MSG_PORT_W-1:0] msg;
		logic [mrj_pkg::COUNT_W-1:0]    count;
	} ring_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [mrj_pkg::CAP_W-1:0]      cfg_wdata;
	logic                           in_valid;
	logic                           in_stall;
	logic [mrj_pkg::OP_W-1:0]       op;
	logic [mrj_pkg::MSG_PORT_W-1:0] message;
	logic                           out_valid;
	logic                           out_stall;
	logic [mrj_pkg::STATUS_W-1:0]   status;
	logic [mrj_pkg::MSG_PORT_W-1:0] message_out;
	logic [mrj_pkg::COUNT_W-1:0]    count;

	// Predicted ring state
	logic [mrj_pkg::MSG_PORT_W-1:0] ring_slots [0:RING_DEPTH];
	int                             head_idx;
	int                             tail_idx;
	int                             held;
	logic [mrj_pkg::CAP_W-1:0]      capacity_reg;

	ring_result_t pending_results[$];

	int send_idle_pct;
	int recv_idle_pct;
	int mismatches;
	int results_checked;
	int cycle_count;
	int op_total [4];
	int full_total;
	int empty_total;
	int capacity_writes;

	message_ring_with_jam_core u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.op         (op),
		.message    (message),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.status     (status),
		.message_out(message_out),
		.count      (count)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Bound the run; a hang anywhere ends here.
	initial begin
		cycle_count = 0;
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("timeout after %0d cycles", cycle_count);
				$display("simulation failed");
				$finish;
			end
		end
	end

	// Receiver: stall the result channel at the current idling rate.
	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		if (mismatches < PRINT_LIMIT)
			$display("mismatch at cycle %0d: %s expected 0x%0h got 0x%0h",
				cycle_count, what, want, got);
		mismatches++;
	endtask

	// Monitor: compare each result transfer against the oldest prediction.
	initial begin
		ring_result_t want;
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
				if (pending_results.size() == 0) begin
					report_mismatch("unexpected result, status", '0, 32'(status));
				end else begin
					want = pending_results.pop_front();
					results_checked++;
					if (status !== want.status)
						report_mismatch("status", 32'(want.status), 32'(status));
					if (message_out !== want.msg)
						report_mismatch("message_out", want.msg, message_out);
					if (count !== want.count)
						report_mismatch("count", 32'(want.count), 32'(count));
				end
			end
		end
	end

	function automatic int effective_capacity();
		return (capacity_reg > RING_DEPTH) ? RING_DEPTH : int'(capacity_reg);
	endfunction

	// Advance the predicted ring by one operation and return its result.
	function automatic ring_result_t ring_predict(mrj_pkg::op_t o,
			logic [mrj_pkg::MSG_PORT_W-1:0] m);
		ring_result_t r;
		int cap;
		cap = effective_capacity();
		r.status = mrj_pkg::ST_OK;
		r.msg = '0;
		case (o)
			mrj_pkg::OP_POST: begin
				if (held >= cap) begin
					r.status = mrj_pkg::ST_FULL;
				end else begin
					ring_slots[tail_idx] = m;
					tail_idx = (tail_idx + 1 > cap) ? 0 : tail_idx + 1;
					held++;
				end
			end
			mrj_pkg::OP_JAM: begin
				if (held >= cap + 1) begin
					r.status = mrj_pkg::ST_FULL;
				end else begin
					head_idx = (head_idx == 0) ? cap : head_idx - 1;
					ring_slots[head_idx] = m;
					held++;
				end
			end
			mrj_pkg::OP_ACCEPT: begin
				if (held == 0) begin
					r.status = mrj_pkg::ST_EMPTY;
				end else begin
					r.msg = ring_slots[head_idx];
					head_idx = (head_idx + 1 > cap) ? 0 : head_idx + 1;
					held--;
				end
			end
			default: begin
				if (held != 0)
					r.msg = ring_slots[head_idx];
			end
		endcase
		r.count = held[mrj_pkg::COUNT_W-1:0];
		if (r.status == mrj_pkg::ST_FULL)
			full_total++;
		if (r.status == mrj_pkg::ST_EMPTY)
			empty_total++;
		op_total[o]++;
		return r;
	endfunction

	// Offer one operation; predict its result once it transfers in.
	task automatic send_op(mrj_pkg::op_t o, logic [mrj_pkg::MSG_PORT_W-1:0] m);
		while ($urandom_range(99) < send_idle_pct) begin
			@(negedge clk);
			in_valid = 1'b0;
		end
		@(negedge clk);
		in_valid = 1'b1;
		op = o;
		message = m;
		forever begin
			@(posedge clk);
			if (in_stall === 1'b0)
				break;
		end
		pending_results.push_back(ring_predict(o, m));
	endtask

	// Drop valid and hold until every predicted result has transferred out.
	task automatic wait_for_results();
		@(negedge clk);
		in_valid = 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_capacity(logic [mrj_pkg::CAP_W-1:0] value);
		wait_for_results();
		repeat (3) @(posedge clk);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = value;
		@(posedge clk);
		// A capacity write empties the ring.
		capacity_reg = value;
		head_idx = 0;
		tail_idx = 0;
		held = 0;
		capacity_writes++;
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	task automatic set_idling(int sender_pct, int receiver_pct);
		send_idle_pct = sender_pct;
		recv_idle_pct = receiver_pct;
	endtask

	// Reset capacity of 64: empty inquiry and accept, extreme message words.
	task automatic test_reset_defaults();
		send_op(mrj_pkg::OP_INQUIRY, 32'hFFFF_FFFF);
		send_op(mrj_pkg::OP_ACCEPT, 32'h0);
		send_op(mrj_pkg::OP_POST, 32'h0000_0000);
		send_op(mrj_pkg::OP_POST, 32'hFFFF_FFFF);
		send_op(mrj_pkg::OP_INQUIRY, 32'h0);
		send_op(mrj_pkg::OP_ACCEPT, 32'h0);
		send_op(mrj_pkg::OP_ACCEPT, 32'h0);
		send_op(mrj_pkg::OP_ACCEPT, 32'h0);
	endtask

	// Capacity zero: every post is refused, one jam fits the spare slot.
	task automatic test_capacity_zero();
		write_capacity(7'd0);
		send_op(mrj_pkg::OP_POST, 32'h1234_5678);
		send_op(mrj_pkg::OP_JAM, 32'hA5A5_5A5A);
		send_op(mrj_pkg::OP_JAM, 32'h5A5A_A5A5);
		send_op(mrj_pkg::OP_INQUIRY, 32'h0);
		send_op(mrj_pkg::OP_ACCEPT, 32'h0);
		send_op(mrj_pkg::OP_ACCEPT, 32'h0);
	endtask

	// Two-message ring: refused post, jam into the spare slot, index wrap.
	task automatic test_small_ring_wrap();
		write_capacity(7'd2);
		send_op(mrj_pkg::OP_POST, 32'h0000_00A1);
		send_op(mrj_pkg::OP_POST, 32'h0000_00B2);
		send_op(mrj_pkg::OP_POST, 32'h0000_00C3);
		send_op(mrj_pkg::OP_JAM, 32'h0000_00D4);
		send_op(mrj_pkg::OP_JAM, 32'h0000_00E5);
		send_op(mrj_pkg::OP_INQUIRY, 32'h0);
		send_op(mrj_pkg::OP_ACCEPT, 32'h0);
		send_op(mrj_pkg::OP_ACCEPT, 32'h0);
		send_op(mrj_pkg::OP_ACCEPT, 32'h0);
		send_op(mrj_pkg::OP_ACCEPT, 32'h0);
	endtask

	// Capacity above the ring depth saturates; fill past full and drain.
	task automatic test_saturated_capacity();
		write_capacity(7'd127);
		repeat (RING_DEPTH + 1) send_op(mrj_pkg::OP_POST, $urandom);
		send_op(mrj_pkg::OP_JAM, $urandom);
		send_op(mrj_pkg::OP_JAM, $urandom);
		send_op(mrj_pkg::OP_INQUIRY, 32'h0);
		repeat (RING_DEPTH + 2) send_op(mrj_pkg::OP_ACCEPT, $urandom);
	endtask

	// Mostly inserts for a high bias, mostly removals for a low one, some noise.
	function automatic mrj_pkg::op_t pick_op(int bias);
		int r;
		r = $urandom_range(99);
		if (r < 5)
			return mrj_pkg::op_t'($urandom_range(3));
		if ($urandom_range(99) < bias)
			return ($urandom_range(9) < 7) ? mrj_pkg::OP_POST : mrj_pkg::OP_JAM;
		return ($urandom_range(9) < 8) ? mrj_pkg::OP_ACCEPT : mrj_pkg::OP_INQUIRY;
	endfunction

	task automatic run_ring_phase(logic [mrj_pkg::CAP_W-1:0] cap);
		int n_items;
		int tide;
		int bias;
		int pick;
		write_capacity(cap);
		n_items = 24 + 2 * effective_capacity();
		tide = (effective_capacity() > 8) ? effective_capacity() : 8;
		bias = 85;
		for (int i = 0; i < n_items; i++) begin
			if (i % tide == 0) begin
				pick = $urandom_range(2);
				bias = (pick == 0) ? 85 : (pick == 1) ? 15 : 50;
			end
			// Pause the sender once per phase until the ring has answered everything.
			if (i == n_items / 2)
				wait_for_results();
			send_op(pick_op(bias), $urandom);
		end
	endtask

	task automatic test_random_traffic();
		int phase_caps [7];
		for (int k = 0; k < 3; k++) begin
			if (k == 0)
				set_idling(34, 72);
			else if (k == 1)
				set_idling(72, 34);
			else
				set_idling(0, 0);
			phase_caps = '{1, 2, 3, 6, 64, 0, 0};
			phase_caps[5] = $urandom_range(12);
			phase_caps[6] = (k == 0) ? 127 : (k == 1) ? 0 : $urandom_range(127);
			foreach (phase_caps[p])
				run_ring_phase(phase_caps[p][mrj_pkg::CAP_W-1:0]);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		in_valid = 1'b0;
		op = mrj_pkg::OP_POST;
		message = '0;
		head_idx = 0;
		tail_idx = 0;
		held = 0;
		capacity_reg = mrj_pkg::CAP_RESET;
		mismatches = 0;
		results_checked = 0;
		full_total = 0;
		empty_total = 0;
		capacity_writes = 0;
		foreach (op_total[i])
			op_total[i] = 0;
		set_idling(34, 72);
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_reset_defaults();
		test_capacity_zero();
		test_small_ring_wrap();
		test_saturated_capacity();
		test_random_traffic();

		wait_for_results();
		repeat (4) @(posedge clk);
		$display("checked %0d results: %0d post, %0d jam, %0d accept, %0d inquiry",
			results_checked, op_total[mrj_pkg::OP_POST], op_total[mrj_pkg::OP_JAM],
			op_total[mrj_pkg::OP_ACCEPT], op_total[mrj_pkg::OP_INQUIRY]);
		$display("%0d refused as full, %0d accepts on empty, %0d capacity writes",
			full_total, empty_total, capacity_writes);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("simulation failed");
		end
		$finish;
	end

endmodule
